/* rtl/dpc_pkg.sv */
// Shared types and widths for the disc pair collision time pipeline.
// Used by dpc_root_search and disc_pair_collision_time; depends on nothing.
`timescale 1ns / 1ps

package dpc_pkg;

  localparam int DAT_W    = 32;   // port field width
  localparam int RAD_W    = 31;   // radius register width
  localparam logic [RAD_W-1:0] RADIUS_RST = 31'd65536;
  localparam int FRAC_BITS = 16;  // fraction bits of every Q field; widths below assume it

  localparam int PROD_W   = 65;   // velocity times elapsed time
  localparam int DX_W     = 57;   // advanced position difference, signed
  localparam int DXM_W    = 56;   // its magnitude
  localparam int HALF_W   = 28;   // half of the magnitude for partial products
  localparam int DVM_W    = 32;   // velocity difference magnitude
  localparam int VV_W     = 64;
  localparam int XVP_W    = HALF_W + DVM_W;
  localparam int XXP_W    = 2 * HALF_W;
  localparam int DD_W     = 64;
  localparam int XV_W     = 88;
  localparam int XX_W     = 112;
  localparam int A_W      = 66;   // |dv|^2
  localparam int S_W      = 90;   // dp . dv, signed
  localparam int C_W      = 114;  // |dp|^2 - (2R)^2, signed

  localparam int T_W      = 33;   // root offset bits
  localparam int SRCH_N   = T_W;  // one search stage per offset bit
  localparam int FRONT_N  = 8;    // stages ahead of the search
  localparam int F_W      = 136;  // quadratic value, signed
  localparam int AO_W     = 100;  // a * offset
  localparam int S2F_W    = 100;  // scaled linear terms, signed

  // discriminant products, accumulated one partial product per stage
  localparam int ACC_W    = 180;
  localparam int SMAG_W   = S_W;
  localparam int SCH_W    = 30;
  localparam int ACH_W    = 22;
  localparam int CCH_W    = 29;
  localparam int CPOS_W   = 4 * CCH_W;
  localparam int SS_PP_N  = 9;
  localparam int AC_PP_N  = 12;
  localparam int DISC_K   = AC_PP_N + 1;

  typedef struct packed {
    logic signed [DAT_W-1:0] first_x;
    logic signed [DAT_W-1:0] first_y;
    logic signed [DAT_W-1:0] first_vx;
    logic signed [DAT_W-1:0] first_vy;
    logic        [DAT_W-1:0] first_time;
    logic signed [DAT_W-1:0] second_x;
    logic signed [DAT_W-1:0] second_y;
    logic signed [DAT_W-1:0] second_vx;
    logic signed [DAT_W-1:0] second_vy;
    logic        [DAT_W-1:0] second_time;
  } pair_item_t;

  typedef struct packed {
    logic [DAT_W-1:0] hit_time;
    logic             no_hit;
  } hit_item_t;

  typedef struct packed {
    logic        [DAT_W-1:0]  tm;
    logic        [A_W-1:0]    a;
    logic signed [S2F_W-1:0]  s2f;
    logic signed [S2F_W-1:0]  msf;
    logic signed [F_W-1:0]    fo;
    logic        [SMAG_W-1:0] smag;
    logic        [CPOS_W-1:0] cpos;
    logic                     cs_pos;
    logic                     found_pre;
  } srch_seed_t;

  typedef struct packed {
    logic        [DAT_W-1:0]  tm;
    logic        [A_W-1:0]    a;
    logic signed [S2F_W-1:0]  s2f;
    logic signed [S2F_W-1:0]  msf;
    logic        [SMAG_W-1:0] smag;
    logic        [CPOS_W-1:0] cpos;
    logic                     cs_pos;
    logic                     found_pre;
    logic        [T_W-1:0]    off;
    logic signed [F_W-1:0]    fo;
    logic        [AO_W-1:0]   ao;
    logic        [ACC_W-1:0]  pp_ss;
    logic        [ACC_W-1:0]  pp_ac;
    logic        [ACC_W-1:0]  acc_ss;
    logic        [ACC_W-1:0]  acc_ac;
    logic                     disc_ge;
  } srch_st_t;

endpackage

/* rtl/dpc_root_search.sv */
// Bit-per-stage root search of the collision quadratic plus discriminant check.
// Depends on dpc_pkg; stage enables come from the top level valid chain.
`timescale 1ns / 1ps

module dpc_root_search (
  input  logic                        clk,
  input  logic [dpc_pkg::SRCH_N:0]    adv,
  input  dpc_pkg::srch_seed_t         seed,
  output dpc_pkg::hit_item_t          result
);

  dpc_pkg::srch_st_t st [0:dpc_pkg::SRCH_N];

  always_comb begin
    st[0]           = '0;
    st[0].tm        = seed.tm;
    st[0].a         = seed.a;
    st[0].s2f       = seed.s2f;
    st[0].msf       = seed.msf;
    st[0].smag      = seed.smag;
    st[0].cpos      = seed.cpos;
    st[0].cs_pos    = seed.cs_pos;
    st[0].found_pre = seed.found_pre;
    st[0].fo        = seed.fo;
  end

  for (genvar k = 0; k < dpc_pkg::SRCH_N; k++) begin : g_stage
    localparam int BIT = dpc_pkg::T_W - 1 - k;

    dpc_pkg::srch_st_t                 nx;
    logic [dpc_pkg::AO_W-1:0]          at;
    logic signed [dpc_pkg::F_W-1:0]    t_ao;
    logic signed [dpc_pkg::F_W-1:0]    t_a;
    logic signed [dpc_pkg::F_W-1:0]    t_s;
    logic signed [dpc_pkg::F_W-1:0]    fc;
    logic                              at_ok;
    logic                              ok;
    logic [dpc_pkg::ACC_W-1:0]         pp_ss;
    logic [dpc_pkg::ACC_W-1:0]         pp_ac;

    if (k < dpc_pkg::SS_PP_N) begin : g_ss
      localparam int SI = k / 3;
      localparam int SJ = k % 3;
      logic [2*dpc_pkg::SCH_W-1:0] prod;
      assign prod  = st[k].smag[SI*dpc_pkg::SCH_W +: dpc_pkg::SCH_W]
                   * st[k].smag[SJ*dpc_pkg::SCH_W +: dpc_pkg::SCH_W];
      assign pp_ss = dpc_pkg::ACC_W'(prod) << (dpc_pkg::SCH_W * (SI + SJ));
    end else begin : g_ss_idle
      assign pp_ss = '0;
    end

    if (k < dpc_pkg::AC_PP_N) begin : g_ac
      localparam int AI = k / 4;
      localparam int CJ = k % 4;
      logic [dpc_pkg::ACH_W+dpc_pkg::CCH_W-1:0] prod;
      assign prod  = st[k].a[AI*dpc_pkg::ACH_W +: dpc_pkg::ACH_W]
                   * st[k].cpos[CJ*dpc_pkg::CCH_W +: dpc_pkg::CCH_W];
      assign pp_ac = dpc_pkg::ACC_W'(prod)
                     << (dpc_pkg::ACH_W * AI + dpc_pkg::CCH_W * CJ);
    end else begin : g_ac_idle
      assign pp_ac = '0;
    end

    // f(off + 2^b) = f(off) + 2^(b+1)*a*off + a*2^(2b) + s2f*2^b
    assign at    = st[k].ao + (dpc_pkg::AO_W'(st[k].a) << BIT);
    assign t_ao  = dpc_pkg::F_W'(st[k].ao) << (BIT + 1);
    assign t_a   = dpc_pkg::F_W'(st[k].a) << (2 * BIT);
    assign t_s   = dpc_pkg::F_W'(st[k].s2f) <<< BIT;
    assign fc    = st[k].fo + t_ao + t_a + t_s;
    assign at_ok = $signed({1'b0, at}) <= $signed({st[k].msf[dpc_pkg::S2F_W-1], st[k].msf});
    assign ok    = st[k].cs_pos ? (at_ok && !fc[dpc_pkg::F_W-1])
                                : (fc[dpc_pkg::F_W-1] || (fc == '0));

    always_comb begin
      nx        = st[k];
      nx.pp_ss  = pp_ss;
      nx.pp_ac  = pp_ac;
      nx.acc_ss = st[k].acc_ss + st[k].pp_ss;
      nx.acc_ac = st[k].acc_ac + st[k].pp_ac;
      if (k == dpc_pkg::DISC_K) begin
        nx.disc_ge = st[k].acc_ss >= st[k].acc_ac;
      end
      if (ok) begin
        nx.off = st[k].off | (dpc_pkg::T_W'(1) << BIT);
        nx.fo  = fc;
        nx.ao  = at;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        st[k+1] <= nx;
      end
    end
  end

  logic [dpc_pkg::DAT_W+1:0] total;
  logic                      found;

  assign total = (dpc_pkg::DAT_W + 2)'(st[dpc_pkg::SRCH_N].tm)
               + (dpc_pkg::DAT_W + 2)'(st[dpc_pkg::SRCH_N].off);
  assign found = st[dpc_pkg::SRCH_N].found_pre
              && (!st[dpc_pkg::SRCH_N].cs_pos || st[dpc_pkg::SRCH_N].disc_ge);

  always_ff @(posedge clk) begin
    if (adv[dpc_pkg::SRCH_N]) begin
      if (!found) begin
        result.hit_time <= '0;
        result.no_hit   <= 1'b1;
      end else if (total[dpc_pkg::DAT_W+1:dpc_pkg::DAT_W] != 2'b00) begin
        // saturate on overflow
        result.hit_time <= '1;
        result.no_hit   <= 1'b1;
      end else begin
        result.hit_time <= total[dpc_pkg::DAT_W-1:0];
        result.no_hit   <= 1'b0;
      end
    end
  end

endmodule

/* rtl/disc_pair_collision_time.sv */
// Collision time of two equal hard discs: top level, front arithmetic and flow control.
// Depends on dpc_pkg and dpc_root_search.
//
// Usage:
//   pair channel (pair_valid / pair_ready / pair) takes one disc pair per item.
//   hit channel (hit_valid / hit_ready / hit) returns one result per item, in order.
//   cfg_we / cfg_wdata write the disc radius; write it only while the block is idle.
// Path from acceptance to hit_valid: 8 stages of advance, products and quadratic
//   setup, 33 search stages (one root bit each), then the output register.
// Throughput: one item per cycle while hit_ready is high, set by the fully pipelined datapath.
// Reset: all stage valid bits clear, radius returns to 1.0.
// Stall: when hit_ready is low, the items behind the output register keep moving
//   into empty stages; pair_ready drops only once every stage holds an item.
`timescale 1ns / 1ps

module disc_pair_collision_time (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pair_valid,
  output logic                        pair_ready,
  input  dpc_pkg::pair_item_t         pair,
  output logic                        hit_valid,
  input  logic                        hit_ready,
  output dpc_pkg::hit_item_t          hit,
  input  logic                        cfg_we,
  input  logic [dpc_pkg::RAD_W-1:0]   cfg_wdata
);

  localparam int NS = dpc_pkg::FRONT_N + dpc_pkg::SRCH_N + 1;

  logic [dpc_pkg::RAD_W-1:0] radius;
  logic [NS-1:0]             v;
  logic [NS:0]               en;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= dpc_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  // A stage loads when it is empty or its successor loads.
  always_comb begin
    en[NS] = hit_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (en[NS-1:0] & {v[NS-2:0], pair_valid}) | (~en[NS-1:0] & v);
    end
  end

  assign pair_ready = en[0];
  assign hit_valid  = v[NS-1];

  // Stage 1: pick the older disc, elapsed time, raw differences.
  logic                      older1;
  logic                      f1_older1;
  logic [dpc_pkg::DAT_W-1:0] f1_dt, f1_tm;
  logic signed [dpc_pkg::DAT_W-1:0] f1_vx, f1_vy;
  logic signed [dpc_pkg::DAT_W:0]   f1_dx0, f1_dy0, f1_dvx, f1_dvy;

  assign older1 = pair.first_time <= pair.second_time;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      f1_older1 <= older1;
      f1_dt     <= older1 ? pair.second_time - pair.first_time
                          : pair.first_time - pair.second_time;
      f1_tm     <= older1 ? pair.second_time : pair.first_time;
      f1_vx     <= older1 ? pair.first_vx : pair.second_vx;
      f1_vy     <= older1 ? pair.first_vy : pair.second_vy;
      f1_dx0    <= (dpc_pkg::DAT_W + 1)'(pair.first_x)  - (dpc_pkg::DAT_W + 1)'(pair.second_x);
      f1_dy0    <= (dpc_pkg::DAT_W + 1)'(pair.first_y)  - (dpc_pkg::DAT_W + 1)'(pair.second_y);
      f1_dvx    <= (dpc_pkg::DAT_W + 1)'(pair.first_vx) - (dpc_pkg::DAT_W + 1)'(pair.second_vx);
      f1_dvy    <= (dpc_pkg::DAT_W + 1)'(pair.first_vy) - (dpc_pkg::DAT_W + 1)'(pair.second_vy);
    end
  end

  // Stage 2: displacement products.
  logic                      f2_older1;
  logic [dpc_pkg::DAT_W-1:0] f2_tm;
  logic signed [dpc_pkg::PROD_W-1:0] f2_px, f2_py;
  logic signed [dpc_pkg::DAT_W:0]    f2_dx0, f2_dy0, f2_dvx, f2_dvy;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      f2_older1 <= f1_older1;
      f2_tm     <= f1_tm;
      f2_px     <= $signed(f1_vx) * $signed({1'b0, f1_dt});
      f2_py     <= $signed(f1_vy) * $signed({1'b0, f1_dt});
      f2_dx0    <= f1_dx0;
      f2_dy0    <= f1_dy0;
      f2_dvx    <= f1_dvx;
      f2_dvy    <= f1_dvy;
    end
  end

  // Stage 3: floor the displacement and fold it into the position difference.
  logic signed [dpc_pkg::PROD_W-1:0] shx, shy;
  logic signed [dpc_pkg::DX_W-1:0]   dlx, dly;
  logic [dpc_pkg::DAT_W-1:0]         f3_tm;
  logic signed [dpc_pkg::DX_W-1:0]   f3_dx, f3_dy;
  logic signed [dpc_pkg::DAT_W:0]    f3_dvx, f3_dvy;

  assign shx = f2_px >>> dpc_pkg::FRAC_BITS;
  assign shy = f2_py >>> dpc_pkg::FRAC_BITS;
  assign dlx = shx[dpc_pkg::DX_W-1:0];
  assign dly = shy[dpc_pkg::DX_W-1:0];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      f3_tm  <= f2_tm;
      f3_dx  <= dpc_pkg::DX_W'(f2_dx0) + (f2_older1 ? dlx : -dlx);
      f3_dy  <= dpc_pkg::DX_W'(f2_dy0) + (f2_older1 ? dly : -dly);
      f3_dvx <= f2_dvx;
      f3_dvy <= f2_dvy;
    end
  end

  // Stage 4: magnitudes and signs.
  logic [dpc_pkg::DAT_W-1:0] f4_tm;
  logic [dpc_pkg::DXM_W-1:0] f4_dxm, f4_dym;
  logic [dpc_pkg::DVM_W-1:0] f4_dvxm, f4_dvym;
  logic                      f4_sxv, f4_syv;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      f4_tm   <= f3_tm;
      f4_dxm  <= f3_dx[dpc_pkg::DX_W-1] ? dpc_pkg::DXM_W'(-f3_dx) : dpc_pkg::DXM_W'(f3_dx);
      f4_dym  <= f3_dy[dpc_pkg::DX_W-1] ? dpc_pkg::DXM_W'(-f3_dy) : dpc_pkg::DXM_W'(f3_dy);
      f4_dvxm <= f3_dvx[dpc_pkg::DAT_W] ? dpc_pkg::DVM_W'(-f3_dvx) : dpc_pkg::DVM_W'(f3_dvx);
      f4_dvym <= f3_dvy[dpc_pkg::DAT_W] ? dpc_pkg::DVM_W'(-f3_dvy) : dpc_pkg::DVM_W'(f3_dvy);
      f4_sxv  <= f3_dx[dpc_pkg::DX_W-1] ^ f3_dvx[dpc_pkg::DAT_W];
      f4_syv  <= f3_dy[dpc_pkg::DX_W-1] ^ f3_dvy[dpc_pkg::DAT_W];
    end
  end

  // Stage 5: partial products.
  logic [dpc_pkg::DAT_W-1:0] f5_tm;
  logic [dpc_pkg::VV_W-1:0]  f5_vvx, f5_vvy;
  logic [dpc_pkg::XVP_W-1:0] f5_xvl, f5_xvh, f5_yvl, f5_yvh;
  logic [dpc_pkg::XXP_W-1:0] f5_xll, f5_xlh, f5_xhh, f5_yll, f5_ylh, f5_yhh;
  logic [dpc_pkg::DD_W-1:0]  f5_dd;
  logic                      f5_sxv, f5_syv;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      f5_tm  <= f4_tm;
      f5_vvx <= f4_dvxm * f4_dvxm;
      f5_vvy <= f4_dvym * f4_dvym;
      f5_xvl <= f4_dxm[dpc_pkg::HALF_W-1:0] * f4_dvxm;
      f5_xvh <= f4_dxm[dpc_pkg::DXM_W-1:dpc_pkg::HALF_W] * f4_dvxm;
      f5_yvl <= f4_dym[dpc_pkg::HALF_W-1:0] * f4_dvym;
      f5_yvh <= f4_dym[dpc_pkg::DXM_W-1:dpc_pkg::HALF_W] * f4_dvym;
      f5_xll <= f4_dxm[dpc_pkg::HALF_W-1:0] * f4_dxm[dpc_pkg::HALF_W-1:0];
      f5_xlh <= f4_dxm[dpc_pkg::HALF_W-1:0] * f4_dxm[dpc_pkg::DXM_W-1:dpc_pkg::HALF_W];
      f5_xhh <= f4_dxm[dpc_pkg::DXM_W-1:dpc_pkg::HALF_W]
              * f4_dxm[dpc_pkg::DXM_W-1:dpc_pkg::HALF_W];
      f5_yll <= f4_dym[dpc_pkg::HALF_W-1:0] * f4_dym[dpc_pkg::HALF_W-1:0];
      f5_ylh <= f4_dym[dpc_pkg::HALF_W-1:0] * f4_dym[dpc_pkg::DXM_W-1:dpc_pkg::HALF_W];
      f5_yhh <= f4_dym[dpc_pkg::DXM_W-1:dpc_pkg::HALF_W]
              * f4_dym[dpc_pkg::DXM_W-1:dpc_pkg::HALF_W];
      f5_dd  <= {radius, 1'b0} * {radius, 1'b0};
      f5_sxv <= f4_sxv;
      f5_syv <= f4_syv;
    end
  end

  // Stage 6: per-axis sums.
  logic [dpc_pkg::DAT_W-1:0] f6_tm;
  logic [dpc_pkg::XV_W-1:0]  f6_xv, f6_yv;
  logic [dpc_pkg::XX_W-1:0]  f6_xx, f6_yy;
  logic [dpc_pkg::A_W-1:0]   f6_a;
  logic [dpc_pkg::DD_W-1:0]  f6_dd;
  logic                      f6_sxv, f6_syv;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      f6_tm  <= f5_tm;
      f6_xv  <= dpc_pkg::XV_W'(f5_xvl) + (dpc_pkg::XV_W'(f5_xvh) << dpc_pkg::HALF_W);
      f6_yv  <= dpc_pkg::XV_W'(f5_yvl) + (dpc_pkg::XV_W'(f5_yvh) << dpc_pkg::HALF_W);
      f6_xx  <= dpc_pkg::XX_W'(f5_xll) + (dpc_pkg::XX_W'(f5_xlh) << (dpc_pkg::HALF_W + 1))
              + (dpc_pkg::XX_W'(f5_xhh) << (2 * dpc_pkg::HALF_W));
      f6_yy  <= dpc_pkg::XX_W'(f5_yll) + (dpc_pkg::XX_W'(f5_ylh) << (dpc_pkg::HALF_W + 1))
              + (dpc_pkg::XX_W'(f5_yhh) << (2 * dpc_pkg::HALF_W));
      f6_a   <= dpc_pkg::A_W'(f5_vvx) + dpc_pkg::A_W'(f5_vvy);
      f6_dd  <= f5_dd;
      f6_sxv <= f5_sxv;
      f6_syv <= f5_syv;
    end
  end

  // Stage 7: quadratic coefficients.
  logic signed [dpc_pkg::S_W-1:0] tx, ty;
  logic [dpc_pkg::DAT_W-1:0]      f7_tm;
  logic [dpc_pkg::A_W-1:0]        f7_a;
  logic signed [dpc_pkg::S_W-1:0] f7_s;
  logic signed [dpc_pkg::C_W-1:0] f7_c;

  assign tx = f6_sxv ? -$signed(dpc_pkg::S_W'(f6_xv)) : $signed(dpc_pkg::S_W'(f6_xv));
  assign ty = f6_syv ? -$signed(dpc_pkg::S_W'(f6_yv)) : $signed(dpc_pkg::S_W'(f6_yv));

  always_ff @(posedge clk) begin
    if (en[6]) begin
      f7_tm <= f6_tm;
      f7_a  <= f6_a;
      f7_s  <= tx + ty;
      f7_c  <= $signed(dpc_pkg::C_W'(f6_xx)) + $signed(dpc_pkg::C_W'(f6_yy))
             - $signed(dpc_pkg::C_W'(f6_dd));
    end
  end

  // Stage 8: classify and scale for the search.
  logic                c_zero, c_pos, s_neg;
  dpc_pkg::srch_seed_t f8_seed;

  assign c_zero = f7_c == '0;
  assign c_pos  = !f7_c[dpc_pkg::C_W-1] && !c_zero;
  assign s_neg  = f7_s[dpc_pkg::S_W-1];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      f8_seed.tm        <= f7_tm;
      f8_seed.a         <= f7_a;
      f8_seed.s2f       <= dpc_pkg::S2F_W'(f7_s) <<< (dpc_pkg::FRAC_BITS + 1);
      f8_seed.msf       <= -(dpc_pkg::S2F_W'(f7_s) <<< dpc_pkg::FRAC_BITS);
      f8_seed.fo        <= dpc_pkg::F_W'(f7_c) <<< (2 * dpc_pkg::FRAC_BITS);
      f8_seed.smag      <= s_neg ? dpc_pkg::SMAG_W'(-f7_s) : dpc_pkg::SMAG_W'(f7_s);
      f8_seed.cpos      <= dpc_pkg::CPOS_W'(f7_c[dpc_pkg::C_W-2:0]);
      f8_seed.cs_pos    <= c_pos;
      // drop parallel motion and pairs that only separate
      f8_seed.found_pre <= (f7_a != '0) && !(c_zero && !s_neg) && !(c_pos && !s_neg);
    end
  end

  dpc_root_search u_search (
    .clk    (clk),
    .adv    (en[NS-1:dpc_pkg::FRONT_N]),
    .seed   (f8_seed),
    .result (hit)
  );

`ifndef ASSERT_OFF
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !hit_valid |-> pair_ready)
    else $error("pair_ready low with the output stage empty");

  a_output_loads: assert property (@(posedge clk) disable iff (rst)
    (v[NS-2] && hit_ready) |=> hit_valid)
    else $error("item before the output stage did not advance");

  a_flag_value: assert property (@(posedge clk) disable iff (rst)
    (hit_valid && hit.no_hit) |-> (hit.hit_time == '0 || hit.hit_time == '1))
    else $error("no_hit with a time that is neither zero nor saturated");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (v == '0))
    else $error("stage valid bits not cleared by reset");
`endif

endmodule

/* bench/disc_pair_collision_time_test.sv */
// Testbench for disc_pair_collision_time: directed table, then random disc pairs
// under several idle and stall patterns, checked against a bit-exact predictor.
// Depends on dpc_pkg and the disc_pair_collision_time RTL.
`timescale 1ns / 1ps

module disc_pair_collision_time_test;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    dpc_pkg::pair_item_t pair;
    bit                  known;
    dpc_pkg::hit_item_t  hit;
  } table_row_t;

  localparam int ONE         = 65536;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 175;

  logic                      clk;
  logic                      rst;
  logic                      pair_valid;
  logic                      pair_ready;
  dpc_pkg::pair_item_t       pair;
  logic                      hit_valid;
  logic                      hit_ready;
  dpc_pkg::hit_item_t        hit;
  logic                      cfg_we;
  logic [dpc_pkg::RAD_W-1:0] cfg_wdata;

  dpc_pkg::hit_item_t        pending_hits[$];
  logic [dpc_pkg::RAD_W-1:0] radius_now;
  int                        send_idle;
  int                        recv_idle;
  bit                        hold_req;
  int                        errors;
  int                        cycles;
  table_row_t                rows[$];

  disc_pair_collision_time DUT (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready), .pair(pair),
    .hit_valid(hit_valid), .hit_ready(hit_ready), .hit(hit),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Exact collision time: advance the older disc, then search the root bit by bit.
  function automatic dpc_pkg::hit_item_t predict_hit(dpc_pkg::pair_item_t p,
                                                     logic [dpc_pkg::RAD_W-1:0] rad);
    wide_t x1, y1, vx1, vy1, x2, y2, vx2, vy2, dt, dx, dy, dvx, dvy, d;
    wide_t a, s, c, s2f, c2f, ms2f, tw, f;
    logic [31:0] tm;
    logic [32:0] off;
    logic [34:0] total;
    bit found, ok;
    dpc_pkg::hit_item_t r;
    x1 = p.first_x;   y1 = p.first_y;   vx1 = p.first_vx;  vy1 = p.first_vy;
    x2 = p.second_x;  y2 = p.second_y;  vx2 = p.second_vx; vy2 = p.second_vy;
    if (p.first_time > p.second_time) begin
      tm = p.first_time;
      dt = p.first_time - p.second_time;
      x2 = x2 + ((vx2 * dt) >>> 16);
      y2 = y2 + ((vy2 * dt) >>> 16);
    end else begin
      tm = p.second_time;
      dt = p.second_time - p.first_time;
      x1 = x1 + ((vx1 * dt) >>> 16);
      y1 = y1 + ((vy1 * dt) >>> 16);
    end
    dx = x1 - x2;  dy = y1 - y2;  dvx = vx1 - vx2;  dvy = vy1 - vy2;
    d = rad;
    d = d * 2;
    a = dvx * dvx + dvy * dvy;
    s = dx * dvx + dy * dvy;
    c = dx * dx + dy * dy - d * d;
    s2f = s * 2 * ONE;
    c2f = c * ONE * ONE;
    ms2f = -(s * ONE);
    found = 1'b1;
    if (a == 0) found = 1'b0;
    else if (c == 0 && s >= 0) found = 1'b0;
    else if (c > 0 && (s >= 0 || s * s < a * c)) found = 1'b0;
    r.hit_time = '0;
    r.no_hit   = 1'b1;
    if (found) begin
      off = '0;
      for (int b = 32; b >= 0; b--) begin
        tw = off | (33'd1 << b);
        f = a * tw * tw + s2f * tw + c2f;
        if (c > 0) ok = (tw * a <= ms2f) && (f >= 0);
        else ok = (f <= 0);
        if (ok) off = off | (33'd1 << b);
      end
      total = tm + off;
      if (total > 35'h0_FFFF_FFFF) begin
        r.hit_time = 32'hFFFF_FFFF;
      end else begin
        r.hit_time = total[31:0];
        r.no_hit   = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic dpc_pkg::pair_item_t make_pair(int x1, int y1, int vx1, int vy1, int t1,
                                                    int x2, int y2, int vx2, int vy2, int t2);
    dpc_pkg::pair_item_t p;
    p.first_x = x1;   p.first_y = y1;   p.first_vx = vx1;  p.first_vy = vy1;
    p.first_time = t1;
    p.second_x = x2;  p.second_y = y2;  p.second_vx = vx2; p.second_vy = vy2;
    p.second_time = t2;
    return p;
  endfunction

  function automatic int spread(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Mostly nearby discs with modest speeds so collisions happen; some raw noise.
  function automatic dpc_pkg::pair_item_t random_pair();
    dpc_pkg::pair_item_t p;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      p = make_pair(spread(8 * ONE), spread(8 * ONE), spread(2 * ONE), spread(2 * ONE),
                    $urandom_range(0, 4 * ONE),
                    spread(8 * ONE), spread(8 * ONE), spread(2 * ONE), spread(2 * ONE),
                    $urandom_range(0, 4 * ONE));
      if (kind == 9) begin
        p.first_time  = 32'hFFFF_0000 + $urandom_range(0, ONE - 1);
        p.second_time = 32'hFFFF_0000 + $urandom_range(0, ONE - 1);
      end
    end
    return p;
  endfunction

  // Valid stays high after acceptance until the next idle cycle or drain drops it.
  task automatic send_pair(dpc_pkg::pair_item_t p, bit known, dpc_pkg::hit_item_t h);
    while ($urandom_range(0, 99) < send_idle) begin
      pair_valid <= 1'b0;
      @(posedge clk);
    end
    pair_valid <= 1'b1;
    pair       <= p;
    pending_hits.push_back(known ? h : predict_hit(p, radius_now));
    do @(posedge clk); while (!pair_ready);
  endtask

  task automatic write_radius(logic [dpc_pkg::RAD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we     <= 1'b0;
    radius_now = value;
  endtask

  task automatic drain();
    pair_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic random_phase(int s_idle, int r_idle, logic [dpc_pkg::RAD_W-1:0] rad,
                              bit hold);
    dpc_pkg::hit_item_t none;
    none = '0;
    send_idle = s_idle;
    recv_idle = r_idle;
    write_radius(rad);
    if (hold) hold_req = 1'b1;
    repeat (PHASE_ITEMS) send_pair(random_pair(), 1'b0, none);
    drain();
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    hit_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hit_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      hit_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && hit_valid && hit_ready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected hit item %h", $time, hit);
        errors++;
      end else begin
        if (hit.hit_time !== pending_hits[0].hit_time) begin
          $display("%0t: hit_time expected %h actual %h", $time,
                   pending_hits[0].hit_time, hit.hit_time);
          errors++;
        end
        if (hit.no_hit !== pending_hits[0].no_hit) begin
          $display("%0t: no_hit expected %b actual %b", $time,
                   pending_hits[0].no_hit, hit.no_hit);
          errors++;
        end
        void'(pending_hits.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    dpc_pkg::hit_item_t none;
    none = '0;
    errors = 0;  cycles = 0;  hold_req = 1'b0;
    send_idle = 0;  recv_idle = 0;
    radius_now = dpc_pkg::RADIUS_RST;
    rst <= 1'b1;  pair_valid <= 1'b0;  pair <= '0;
    cfg_we <= 1'b0;  cfg_wdata <= '0;

    // at rest, no relative motion
    rows.push_back('{make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{32'd0, 1'b1}});
    // head-on, gap of 2.0 closed at 1.0 per unit time
    rows.push_back('{make_pair(0, 0, ONE, 0, 0, 4 * ONE, 0, 0, 0, 0), 1,
                     '{32'h0002_0000, 1'b0}});
    // same contact after the latest time: saturates
    rows.push_back('{make_pair(0, 0, ONE, 0, -1, 4 * ONE, 0, 0, 0, -1), 1,
                     '{32'hFFFF_FFFF, 1'b1}});
    // apart and moving away
    rows.push_back('{make_pair(0, 0, -ONE, 0, 0, 4 * ONE, 0, 0, 0, 0), 1, '{32'd0, 1'b1}});
    // touching and separating
    rows.push_back('{make_pair(0, 0, -ONE, 0, 0, 2 * ONE, 0, 0, 0, 0), 1, '{32'd0, 1'b1}});
    // touching and closing
    rows.push_back('{make_pair(0, 0, ONE, 0, 0, 2 * ONE, 0, 0, 0, 0), 0, none});
    // overlapping now
    rows.push_back('{make_pair(0, 0, 0, ONE, 5, ONE, 0, 0, 0, 5), 0, none});
    // passing by, discriminant negative
    rows.push_back('{make_pair(0, 0, ONE, 0, 0, 4 * ONE, 3 * ONE, 0, 0, 0), 0, none});
    // root below one LSB
    rows.push_back('{make_pair(0, 0, 32'h7FFF_FFFF, 0, 7, 2 * ONE + 1, 0, 0, 0, 7), 0, none});
    // first disc older, second older
    rows.push_back('{make_pair(-ONE, 0, ONE, -3, 0, 4 * ONE, 0, -ONE, 0, ONE), 0, none});
    rows.push_back('{make_pair(0, ONE, 0, -ONE, 3 * ONE, 0, 6 * ONE, 7, -ONE, ONE), 0, none});
    rows.push_back('{make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               -1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, -1), 0, none});
    rows.push_back('{make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 0), 0, none});
    rows.push_back('{make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                               0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, -1), 0, none});
    rows.push_back('{make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                               -1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                               32'h7FFF_FFFF, 0), 0, none});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_pair(rows[i].pair, rows[i].known, rows[i].hit);
    drain();

    random_phase(0, 0, dpc_pkg::RADIUS_RST, 1'b1);
    random_phase(59, 0, 31'd0, 1'b0);
    random_phase(0, 59, 31'h7FFF_FFFF, 1'b0);
    random_phase(21, 21, $urandom_range(ONE / 4, 4 * ONE), 1'b0);

    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
